// ===== hw/rtl/cmav_pkg.sv =====
// shared types and constants for the centered moving average unit
`default_nettype none

package cmav_pkg;

  localparam int HALF_WIDTH_W = 5;
  localparam logic [HALF_WIDTH_W-1:0] HALF_WIDTH_RESET = 5'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cmav_if.sv =====
// handshake channels for samples, averages and the half width register
`default_nettype none

interface cmav_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           series_start;

  modport source (output valid, sample, series_start, input ready);
  modport sink (input valid, sample, series_start, output ready);
endinterface

interface cmav_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;

  modport source (output valid, average, input ready);
  modport sink (input valid, average, output ready);
endinterface

interface cmav_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [cmav_pkg::HALF_WIDTH_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cmav_delay_line.sv =====
// circular sample store, one write and one registered read per cycle
`default_nettype none

module cmav_delay_line #(
  parameter int DEPTH        = 63,
  parameter int SAMPLE_WIDTH = 16,
  parameter int PTR_W        = 6
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [PTR_W-1:0]        waddr,
  input  wire logic [SAMPLE_WIDTH-1:0] wdata,
  input  wire logic [PTR_W-1:0]        raddr,
  output logic      [SAMPLE_WIDTH-1:0] rdata
);

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cmav_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module cmav_div #(
  parameter int SUM_W = 22,
  parameter int LEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output logic                  done,
  output logic      [SUM_W-1:0] quotient
);

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;

  assign trial = {rem, quotient[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign done  = busy && (count == CNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
      end
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // no borrow means the divisor fits into the partial remainder
      if (!diff[LEN_W]) begin
        rem      <= diff[LEN_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b1};
      end else begin
        rem      <= trial[LEN_W-1:0];
        quotient <= {quotient[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/centered_moving_average_unit.sv =====
// top level: centered moving average over a configurable 2h+1 sample window
`default_nettype none

// Each sample passes through these steps from acceptance until the unit is ready again:
// in ST_IDLE it is accepted and the leaving sample is read from the delay line, in
// ST_UPDATE the running sum is updated and the new sample stored, in ST_DIV the shared
// restoring divider computes one quotient bit per cycle, and in ST_FINISH the average
// is handed to the output register, waiting while that register still holds an
// untaken average. Samples that do not complete a window skip the divider. The
// output register lets a new sample enter while an average still waits to be taken.
// Writing half_width restarts the window; values above MAX_HALF_WIDTH saturate.
module centered_moving_average_unit #(
  parameter int MAX_HALF_WIDTH = 31,
  parameter int SAMPLE_WIDTH   = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  cmav_in_if.sink    samples,
  cmav_out_if.source averages,
  cmav_cfg_if.sink   cfg
);

  localparam int DEPTH  = 2 * MAX_HALF_WIDTH + 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_WIDTH + $clog2(DEPTH);
  localparam int CALC_W = LEN_W + 1;

  cmav_pkg::state_t state, state_next;

  logic [cmav_pkg::HALF_WIDTH_W-1:0] half_width;
  logic [LEN_W-1:0]                  len;
  logic [LEN_W-1:0]                  fill;
  logic [PTR_W-1:0]                  wp;
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           sum_next;
  logic signed [SAMPLE_WIDTH-1:0]    x;
  logic                              full;
  logic                              neg;
  logic                              produce;
  logic                              in_acc;
  logic                              cfg_acc;
  logic                              load_out;
  logic                              mem_we;
  logic                              div_start;
  logic                              div_done;
  logic [SUM_W-1:0]                  quotient;
  logic [SUM_W-1:0]                  mag;
  logic [SAMPLE_WIDTH-1:0]           old_sample;
  logic [PTR_W-1:0]                  old_addr;
  logic [CALC_W-1:0]                 wp_ext;
  logic [CALC_W-1:0]                 len_ext;
  logic [CALC_W-1:0]                 old_ext;
  logic [LEN_W-1:0]                  fill_eff;
  logic [SAMPLE_WIDTH-1:0]           q_trunc;
  logic                              out_valid;
  logic signed [SAMPLE_WIDTH-1:0]    out_avg;

  assign in_acc  = samples.valid && samples.ready;
  assign cfg_acc = cfg.valid && cfg.ready;

  // effective window length with saturation of the half width
  always_comb begin
    if (int'(half_width) > MAX_HALF_WIDTH) begin
      len = LEN_W'(DEPTH);
    end else begin
      len = LEN_W'({half_width, 1'b1});
    end
  end

  // slot of the sample that leaves the window
  always_comb begin
    wp_ext  = CALC_W'(wp);
    len_ext = CALC_W'(len);
    if (wp_ext >= len_ext) begin
      old_ext = wp_ext - len_ext;
    end else begin
      old_ext = wp_ext + CALC_W'(DEPTH) - len_ext;
    end
    old_addr = old_ext[PTR_W-1:0];
  end

  assign fill_eff = samples.series_start ? '0 : fill;

  always_comb begin
    sum_next = sum + {{(SUM_W-SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
    if (full) begin
      sum_next = sum_next
               - {{(SUM_W-SAMPLE_WIDTH){old_sample[SAMPLE_WIDTH-1]}}, old_sample};
    end
  end

  assign mag     = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
  assign produce = full || ((fill + LEN_W'(1)) == len);
  assign q_trunc = quotient[SAMPLE_WIDTH-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cmav_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = cmav_pkg::ST_UPDATE;
        end
      end
      cmav_pkg::ST_UPDATE: begin
        state_next = produce ? cmav_pkg::ST_DIV : cmav_pkg::ST_IDLE;
      end
      cmav_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = cmav_pkg::ST_FINISH;
        end
      end
      cmav_pkg::ST_FINISH: begin
        if (!out_valid || averages.ready) begin
          state_next = cmav_pkg::ST_IDLE;
        end
      end
      default: state_next = cmav_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    samples.ready = 1'b0;
    mem_we        = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state)
      cmav_pkg::ST_IDLE:   samples.ready = !rst;
      cmav_pkg::ST_UPDATE: begin
        mem_we    = 1'b1;
        div_start = produce;
      end
      cmav_pkg::ST_DIV:    ;
      cmav_pkg::ST_FINISH: load_out = !out_valid || averages.ready;
      default:             ;
    endcase
  end

  assign cfg.ready      = !rst;
  assign averages.valid = out_valid;
  assign averages.average = out_avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmav_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= cmav_pkg::HALF_WIDTH_RESET;
      fill       <= '0;
      sum        <= '0;
      wp         <= '0;
      full       <= 1'b0;
    end else if (cfg_acc) begin
      half_width <= cfg.data;
      fill       <= '0;
      sum        <= '0;
    end else if (in_acc) begin
      full <= (fill_eff >= len);
      if (samples.series_start) begin
        fill <= '0;
        sum  <= '0;
      end
    end else if (state == cmav_pkg::ST_UPDATE) begin
      sum <= sum_next;
      if (!full) begin
        fill <= fill + LEN_W'(1);
      end
      wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x <= samples.sample;
    end
    if (div_start) begin
      neg <= sum_next[SUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (averages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_avg <= neg ? (~q_trunc + SAMPLE_WIDTH'(1)) : q_trunc;
    end
  end

  cmav_delay_line #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PTR_W        (PTR_W)
  ) u_delay_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (x),
    .raddr (old_addr),
    .rdata (old_sample)
  );

  cmav_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (len),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/cmav_checker.sv =====
// port-level checks for the centered moving average unit and their binding
`default_nettype none

module cmav_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] average
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // an accepted item keeps the unit busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while previous item in progress");

  // a new average appears only at the end of the work on an item
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("average appeared without work in progress");

  // a stalled average holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(average)))
    else $error("stalled average changed");

endmodule

bind centered_moving_average_unit cmav_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_cmav_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (averages.valid),
  .out_ready (averages.ready),
  .average   (averages.average)
);

`default_nettype wire

// ===== tb/tb_centered_moving_average_unit.sv =====
// self-checking testbench for the centered moving average unit
`default_nettype none

module tb_centered_moving_average_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_WIDTH_W  = cmav_pkg::HALF_WIDTH_W;
  localparam int SAMPLE_W      = 16;
  localparam int MAX_HALF      = 31;
  localparam int LINE_DEPTH    = 2 * MAX_HALF + 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_RUNS
  } rx_mode_t;

  logic clk;
  logic rst;

  cmav_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) sample_ch ();
  cmav_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) average_ch ();
  cmav_cfg_if cfg_ch ();

  centered_moving_average_unit #(
    .MAX_HALF_WIDTH(MAX_HALF),
    .SAMPLE_WIDTH  (SAMPLE_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .averages(average_ch),
    .cfg     (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // window model
  logic [HALF_WIDTH_W-1:0]    cur_half_width;
  logic signed [SAMPLE_W-1:0] win_samples [0:LINE_DEPTH-1];
  longint                     win_sum;
  int                         win_fill;
  int                         win_wr_ptr;

  logic signed [SAMPLE_W-1:0] expected_averages [$];
  logic signed [SAMPLE_W-1:0] want_average;
  int                         mismatch_count;
  int                         cycle_count;

  // sender and receiver control
  int       burst_left;
  bit       tx_gaps_on;
  rx_mode_t rx_mode;
  int       hold_left;
  int       rx_run_left;
  bit       rx_level;

  function automatic void clear_window();
    win_sum  = 0;
    win_fill = 0;
  endfunction

  function automatic void predict_average(input logic signed [SAMPLE_W-1:0] value,
                                          input logic first);
    int     span;
    int     leaving;
    longint mean;
    span = 2 * int'(cur_half_width) + 1;
    if (first) clear_window();
    if (win_fill >= span) begin
      leaving = (win_wr_ptr + LINE_DEPTH - span) % LINE_DEPTH;
      win_sum -= win_samples[leaving];
    end else begin
      win_fill++;
    end
    win_samples[win_wr_ptr] = value;
    win_wr_ptr = (win_wr_ptr + 1) % LINE_DEPTH;
    win_sum += value;
    if (win_fill >= span) begin
      // signed division truncates toward zero
      mean = win_sum / span;
      expected_averages.insert(expected_averages.size(), mean[SAMPLE_W-1:0]);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (tx_gaps_on)
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sample_ch.valid        <= 1'b1;
    sample_ch.sample       <= value;
    sample_ch.series_start <= first;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predict_average(value, first);
  endtask

  // drop valid, let every average come out, then let a windowless item finish
  task automatic finish_phase();
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_width(input logic [HALF_WIDTH_W-1:0] hw);
    finish_phase();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= hw;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cur_half_width = hw;
    clear_window();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // reset window of three, full-scale samples both ways
  task automatic test_full_scale();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  // negative means must round toward zero, not down
  task automatic test_truncation();
    send_sample(-16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd256, 1'b0);
  endtask

  task automatic test_series_restart();
    send_sample(16'sd100, 1'b1);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd300, 1'b1);
    send_sample(16'sd400, 1'b0);
    send_sample(16'sd500, 1'b0);
  endtask

  // window of one passes samples through
  task automatic test_half_width_zero();
    write_half_width('0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(-16'sd1, 1'b0);
  endtask

  // 63-sample window at both full-scale sums, then mixed content
  task automatic test_wide_window();
    write_half_width(HALF_WIDTH_W'(MAX_HALF));
    for (int i = 0; i < 170; i++) begin
      if (i < 70) send_sample(SAMPLE_MIN, i == 0);
      else if (i < 140) send_sample(SAMPLE_MAX, 1'b0);
      else send_sample(random_sample(), $urandom_range(0, 39) == 0);
    end
  endtask

  // receiver holds off long enough that the unit fills and stalls its input
  task automatic test_backpressure();
    write_half_width(HALF_WIDTH_W'(2));
    rx_mode    = RX_ALWAYS;
    tx_gaps_on = 1'b0;
    hold_left  = 400;
    for (int i = 0; i < 60; i++) send_sample(random_sample(), i == 0);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_series();
    int                      budget;
    int                      phase_items;
    int                      series_len;
    int                      span;
    bit                      lead;
    logic [HALF_WIDTH_W-1:0] hw;
    budget = 1750;
    while (budget > 0) begin
      if ($urandom_range(0, 9) < 7) hw = HALF_WIDTH_W'($urandom_range(0, 4));
      else hw = HALF_WIDTH_W'($urandom_range(0, MAX_HALF));
      write_half_width(hw);
      rx_mode     = rx_mode_t'($urandom_range(0, 2));
      tx_gaps_on  = ($urandom_range(0, 3) != 0);
      span        = 2 * int'(hw) + 1;
      phase_items = $urandom_range(40, 120);
      while (phase_items > 0 && budget > 0) begin
        series_len = $urandom_range(1, 3 * span + 8);
        // mostly proper series, a few run on without a start mark
        lead = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < series_len && phase_items > 0 && budget > 0; i++) begin
          send_sample(random_sample(), (i == 0) ? lead : ($urandom_range(0, 59) == 0));
          phase_items--;
          budget--;
        end
      end
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      average_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: average_ch.ready <= 1'b1;
        RX_COIN:   average_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_run_left == 0) begin
            rx_level    = !rx_level;
            rx_run_left = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 40);
          end else begin
            rx_run_left--;
          end
          average_ch.ready <= rx_level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && average_ch.valid && average_ch.ready) begin
      if (expected_averages.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("average %0d arrived with none expected", average_ch.average);
      end else begin
        want_average = expected_averages.pop_front();
        if (average_ch.average !== want_average) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("average mismatch: expected %0d, got %0d",
                     want_average, average_ch.average);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_centered_moving_average_unit NOT OK");
    $finish;
  end

  initial begin
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.sample       = '0;
    sample_ch.series_start = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = '0;
    average_ch.ready       = 1'b0;
    mismatch_count         = 0;
    burst_left             = 0;
    tx_gaps_on             = 1'b1;
    rx_mode                = RX_COIN;
    hold_left              = 0;
    rx_run_left            = 0;
    rx_level               = 1'b0;
    cur_half_width         = cmav_pkg::HALF_WIDTH_RESET;
    win_wr_ptr             = 0;
    clear_window();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_scale();
    test_truncation();
    test_series_restart();
    test_half_width_zero();
    test_wide_window();
    test_backpressure();
    test_random_series();
    finish_phase();

    if (mismatch_count == 0 && expected_averages.size() == 0)
      $display("tb_centered_moving_average_unit OK");
    else
      $display("tb_centered_moving_average_unit NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
